### rtl/core/ondf_pkg.sv
// ----------------------------------------------------------------------------
// ondf_pkg
// Shared constants and helpers for the Oren-Nayar diffuse factor core.
// ----------------------------------------------------------------------------
package ondf_pkg;

  localparam int VEC_FRAC_BITS_DEF = 14;

  localparam logic [15:0] BASE_ROUGH_RST = 16'd1638;

  // Fixed-point constants: Q30 unless named _Q28; TAN_SAT is Q16
  localparam logic [30:0] Q_ONE     = 31'd1073741824;
  localparam logic signed [31:0] COS_LIMIT = 32'sd1073634450;
  localparam logic [32:0] K33_Q28   = 33'd88583700;
  localparam logic [32:0] K09_Q28   = 33'd24159191;
  localparam logic [28:0] K45_Q30   = 29'd483183821;
  localparam logic [30:0] TAN_SAT   = 31'h7FFF_FFFF;

  // Square root and divider geometry
  localparam int SQN_IW = 54;   // projection length squared
  localparam int SQN_OW = 27;
  localparam int SIN_IW = 62;   // 1 - cos^2 in Q60
  localparam int SIN_OW = 31;
  localparam int COEF_QW = 29;  // A and B quotients
  localparam int COEF_DW = 33;
  localparam int MAXC_QW = 30;  // cos dphi quotient
  localparam int MAXC_DW = 55;
  localparam int TAN_QW  = 31;  // tangent quotient
  localparam int TAN_DW  = 31;

  // Arithmetic right shift, rounding half away from zero
  function automatic logic signed [63:0] rsr(input logic signed [63:0] v,
                                             input int unsigned s);
    logic [63:0] m;
    logic        neg;
    neg = v[63];
    m = neg ? 64'(-v) : 64'(v);
    if (s != 0) m = (m + (64'd1 << (s - 1))) >> s;
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

### rtl/core/ondf_dly.sv
// ----------------------------------------------------------------------------
// ondf_dly
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module ondf_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < D; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[D-1];

endmodule

### rtl/core/ondf_isqrt.sv
// ----------------------------------------------------------------------------
// ondf_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ondf_isqrt #(
  parameter int IW = 62
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IW-1:0]     x,
  output logic [IW/2-1:0]   root
);

  localparam int N = IW / 2;

  logic [IW-1:0] x_r [N];
  logic [IW-1:0] r_r [N];

  for (genvar s = 0; s < N; s++) begin : g_stg
    localparam logic [IW-1:0] BIT = {{(IW-1){1'b0}}, 1'b1} << (IW - 2 - 2 * s);
    logic [IW-1:0] x_in;
    logic [IW-1:0] r_in;
    logic [IW-1:0] t;
    logic          ge;
    if (s == 0) begin : g_first
      assign x_in = x;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_r[s-1];
      assign r_in = r_r[s-1];
    end
    assign t  = r_in + BIT;
    assign ge = x_in >= t;
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s] <= ge ? x_in - t : x_in;
        r_r[s] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
      end
    end
  end

  assign root = r_r[N-1][N-1:0];

endmodule

### rtl/core/ondf_div.sv
// ----------------------------------------------------------------------------
// ondf_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor; dividend bits shift in MSB first.
// ----------------------------------------------------------------------------
module ondf_div #(
  parameter int DW = 33,
  parameter int QW = 29
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem0,
  input  logic [QW-1:0] bits,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] bit_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stg
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] b_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;
    if (s == 0) begin : g_first
      assign r_in = rem0;
      assign d_in = den;
      assign b_in = bits;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_r[s-1];
      assign d_in = den_r[s-1];
      assign b_in = bit_r[s-1];
      assign q_in = quo_r[s-1];
    end
    assign sh   = {r_in, b_in[QW-1]};
    assign diff = sh - {1'b0, d_in};
    assign ge   = sh >= {1'b0, d_in};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[DW-1:0] : sh[DW-1:0];
        den_r[s] <= d_in;
        bit_r[s] <= {b_in[QW-2:0], 1'b0};
        quo_r[s] <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

### rtl/core/oren_nayar_diffuse_factor_core.sv
// Throughput: one item per cycle; the whole pipeline holds as one while a
// shown result is stalled. Depth comes from bit-per-stage units in two parallel
// chains: sine roots (31) then tangent divider (31), and projection roots (27)
// then cos dphi divider (30). Reset (rst_n low, synchronous) clears all valid
// bits and sets base_roughness to 1638.
// ----------------------------------------------------------------------------
// oren_nayar_diffuse_factor_core
// Streaming Oren-Nayar diffuse factor, A + B*max(0,cos dphi)*sin a*tan b.
// ----------------------------------------------------------------------------
module oren_nayar_diffuse_factor_core import ondf_pkg::*; #(
  parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic signed [15:0] in_out_dir_x,
  input  logic signed [15:0] in_out_dir_y,
  input  logic signed [15:0] in_out_dir_z,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic               in_use_item_roughness,
  input  logic [15:0]        in_item_roughness,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_diffuse_factor
);

  // Stage map: a name's stage is the number of registers after the port.
  localparam int DEPTH = 70;                 // T1..T70, output register is T71
  localparam int F2 = 2 * VEC_FRAC_BITS;
  localparam int unsigned UP = (F2 >= 30) ? 0 : 30 - F2;
  localparam int unsigned DN = (F2 >= 30) ? F2 - 30 : 0;
  localparam logic signed [63:0] DOT_LIM = 64'sd1 <<< F2;

  // Pipeline moves whenever the output slot is free or being taken.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // ---------------------------------------------------------------- config
  logic [15:0] base_rough_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_rough_r <= BASE_ROUGH_RST;
    end else if (cfg_we) begin
      base_rough_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- valids
  logic [DEPTH-1:0] vld_r;
  logic             out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[DEPTH-1];
    end
  end
  assign out_valid = out_valid_r;

  // ------------------------------------------------- side data shift lines
  logic [95:0] dirs_t3;
  logic [47:0] nrm_t2;
  ondf_dly #(.W(96), .D(3)) u_dly_dirs (
    .clk(clk), .en(en),
    .din({in_out_dir_z, in_out_dir_y, in_out_dir_x, in_dir_z, in_dir_y, in_dir_x}),
    .dout(dirs_t3)
  );
  ondf_dly #(.W(48), .D(2)) u_dly_nrm (
    .clk(clk), .en(en),
    .din({in_normal_z, in_normal_y, in_normal_x}),
    .dout(nrm_t2)
  );

  // ------------------------------------------------ T1: cosine dots, sigma^2
  logic signed [47:0] doti_r, doto_r;
  logic [31:0]        s2_r;
  logic [15:0]        sigma;
  assign sigma = in_use_item_roughness ? in_item_roughness : base_rough_r;

  always_ff @(posedge clk) begin
    if (en) begin
      doti_r <= 48'(32'(in_dir_x) * 32'(in_normal_x)) + 48'(32'(in_dir_y) * 32'(in_normal_y))
              + 48'(32'(in_dir_z) * 32'(in_normal_z));
      doto_r <= 48'(32'(in_out_dir_x) * 32'(in_normal_x))
              + 48'(32'(in_out_dir_y) * 32'(in_normal_y))
              + 48'(32'(in_out_dir_z) * 32'(in_normal_z));
      s2_r   <= 32'(sigma) * 32'(sigma);
    end
  end

  // ------------------------------------ T2: clamp cosines, coefficient setup
  logic signed [31:0] ci_r, co_r, ci_nxt, co_nxt;
  logic [COEF_DW-1:0] dena_r, denb_r, rema_r;
  logic [60:0]        numb_r;

  always_comb begin
    logic signed [63:0] di, d_o;
    di  = 64'(doti_r);
    d_o = 64'(doto_r);
    if (di > DOT_LIM) di = DOT_LIM;
    if (di < -DOT_LIM) di = -DOT_LIM;
    if (d_o > DOT_LIM) d_o = DOT_LIM;
    if (d_o < -DOT_LIM) d_o = -DOT_LIM;
    ci_nxt = 32'(rsr(di, DN) <<< UP);
    co_nxt = 32'(rsr(d_o, DN) <<< UP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ci_r   <= ci_nxt;
      co_r   <= co_nxt;
      dena_r <= 33'(s2_r) + K33_Q28;
      denb_r <= 33'(s2_r) + K09_Q28;
      rema_r <= 33'(s2_r);
      numb_r <= 61'(s2_r) * 61'(K45_Q30);
    end
  end

  // A and B quotients, T2 -> T31
  logic [COEF_QW-1:0] qa_t31, qb_t31, qa_t70, qb_t69;
  ondf_div #(.DW(COEF_DW), .QW(COEF_QW)) u_div_a (
    .clk(clk), .en(en), .rem0(rema_r), .bits('0), .den(dena_r), .quo(qa_t31)
  );
  ondf_div #(.DW(COEF_DW), .QW(COEF_QW)) u_div_b (
    .clk(clk), .en(en), .rem0({1'b0, numb_r[60:29]}), .bits(numb_r[28:0]),
    .den(denb_r), .quo(qb_t31)
  );
  ondf_dly #(.W(COEF_QW), .D(39)) u_dly_qa (
    .clk(clk), .en(en), .din(qa_t31), .dout(qa_t70)
  );
  ondf_dly #(.W(COEF_QW), .D(38)) u_dly_qb (
    .clk(clk), .en(en), .din(qb_t31), .dout(qb_t69)
  );

  // --------------------- T3: tangent-plane products, angle order, near flag
  logic signed [47:0] pi_r [3];
  logic signed [47:0] po_r [3];
  logic signed [15:0] wi_t3 [3];
  logic signed [15:0] wo_t3 [3];
  logic [30:0]        ca_abs_r, cb_abs_r;
  logic               cb_neg_r, near_r;

  always_ff @(posedge clk) begin
    logic signed [31:0] ca, cb;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pi_r[k] <= 48'($signed(nrm_t2[16*k +: 16])) * 48'(ci_r);
        po_r[k] <= 48'($signed(nrm_t2[16*k +: 16])) * 48'(co_r);
      end
      ca = (co_r >= ci_r) ? ci_r : co_r;
      cb = (co_r >= ci_r) ? co_r : ci_r;
      ca_abs_r <= ca[31] ? 31'(-ca) : 31'(ca);
      cb_abs_r <= cb[31] ? 31'(-cb) : 31'(cb);
      cb_neg_r <= cb[31];
      near_r   <= (ci_r >= COS_LIMIT) || (co_r >= COS_LIMIT);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wi_t3[k] = $signed(dirs_t3[16*k +: 16]);
      wo_t3[k] = $signed(dirs_t3[48 + 16*k +: 16]);
    end
  end

  // ---------------------------------------- T4: projections in Q20, squares
  logic signed [27:0] v1_r [3];
  logic signed [27:0] v2_r [3];
  logic [60:0]        sqa_r, sqb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        v1_r[k] <= 28'(rsr((64'(wi_t3[k]) <<< (30 - VEC_FRAC_BITS))
                           - rsr(64'(pi_r[k]), VEC_FRAC_BITS), 10));
        v2_r[k] <= 28'(rsr((64'(wo_t3[k]) <<< (30 - VEC_FRAC_BITS))
                           - rsr(64'(po_r[k]), VEC_FRAC_BITS), 10));
      end
      sqa_r <= 61'(ca_abs_r) * 61'(ca_abs_r);
      sqb_r <= 61'(cb_abs_r) * 61'(cb_abs_r);
    end
  end

  // ------------------------------------- T5: projection products, 1 - cos^2
  logic signed [55:0] pd_r [3];
  logic signed [55:0] p1_r [3];
  logic signed [55:0] p2_r [3];
  logic [SIN_IW-1:0]  xa_r, xb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pd_r[k] <= 56'(v1_r[k]) * 56'(v2_r[k]);
        p1_r[k] <= 56'(v1_r[k]) * 56'(v1_r[k]);
        p2_r[k] <= 56'(v2_r[k]) * 56'(v2_r[k]);
      end
      xa_r <= 62'(Q_ONE) * 62'(Q_ONE) - 62'(sqa_r);
      xb_r <= 62'(Q_ONE) * 62'(Q_ONE) - 62'(sqb_r);
    end
  end

  // Sines, T5 -> T36
  logic [SIN_OW-1:0] sin_a_t36, sin_b_t36, sin_a_t67;
  ondf_isqrt #(.IW(SIN_IW)) u_sqrt_sa (
    .clk(clk), .en(en), .x(xa_r), .root(sin_a_t36)
  );
  ondf_isqrt #(.IW(SIN_IW)) u_sqrt_sb (
    .clk(clk), .en(en), .x(xb_r), .root(sin_b_t36)
  );
  ondf_dly #(.W(SIN_OW), .D(31)) u_dly_sa (
    .clk(clk), .en(en), .din(sin_a_t36), .dout(sin_a_t67)
  );

  // -------------------------------------------------- T6: projection sums
  logic signed [55:0] dot_r;
  logic [SQN_IW-1:0]  n1_r, n2_r;
  always_ff @(posedge clk) begin
    logic signed [55:0] s1, s2;
    if (en) begin
      s1 = p1_r[0] + p1_r[1] + p1_r[2];
      s2 = p2_r[0] + p2_r[1] + p2_r[2];
      dot_r <= pd_r[0] + pd_r[1] + pd_r[2];
      n1_r  <= s1[SQN_IW-1:0];
      n2_r  <= s2[SQN_IW-1:0];
    end
  end

  // Projection lengths, T6 -> T33
  logic [SQN_OW-1:0] len1_t33, len2_t33;
  logic [55:0]       dot_t33;
  logic              near_t33;
  ondf_isqrt #(.IW(SQN_IW)) u_sqrt_n1 (
    .clk(clk), .en(en), .x(n1_r), .root(len1_t33)
  );
  ondf_isqrt #(.IW(SQN_IW)) u_sqrt_n2 (
    .clk(clk), .en(en), .x(n2_r), .root(len2_t33)
  );
  ondf_dly #(.W(56), .D(27)) u_dly_dot (
    .clk(clk), .en(en), .din(dot_r), .dout(dot_t33)
  );
  ondf_dly #(.W(1), .D(30)) u_dly_near (
    .clk(clk), .en(en), .din(near_r), .dout(near_t33)
  );

  // ------------------------------- T34: denominator and degenerate cases
  logic [MAXC_DW-1:0] den_r;
  logic signed [55:0] dot34_r;
  logic               zero34_r;
  always_ff @(posedge clk) begin
    if (en) begin
      den_r    <= MAXC_DW'(56'(len1_t33) * 56'(len2_t33));
      dot34_r  <= $signed(dot_t33);
      zero34_r <= near_t33 || ($signed(dot_t33) <= 0) || (len1_t33 == '0) || (len2_t33 == '0);
    end
  end

  logic               one34;
  logic [MAXC_DW-1:0] remc0;
  assign one34 = !zero34_r && (56'(den_r) <= dot34_r[55:0]);
  assign remc0 = (zero34_r || one34) ? '0 : dot34_r[MAXC_DW-1:0];

  // cos dphi quotient, T34 -> T64
  logic [MAXC_QW-1:0] qc_t64;
  logic               zero_t64, one_t64;
  ondf_div #(.DW(MAXC_DW), .QW(MAXC_QW)) u_div_c (
    .clk(clk), .en(en), .rem0(remc0), .bits('0), .den(den_r), .quo(qc_t64)
  );
  ondf_dly #(.W(2), .D(30)) u_dly_cflg (
    .clk(clk), .en(en), .din({zero34_r, one34}), .dout({zero_t64, one_t64})
  );

  // T65: max(0, cos dphi) in Q30
  logic [30:0] maxcos_r, maxcos_t67;
  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_t64) begin
        maxcos_r <= '0;
      end else if (one_t64) begin
        maxcos_r <= Q_ONE;
      end else begin
        maxcos_r <= 31'(qc_t64);
      end
    end
  end
  ondf_dly #(.W(31), .D(2)) u_dly_mc (
    .clk(clk), .en(en), .din(maxcos_r), .dout(maxcos_t67)
  );

  // --------------------------------------- tangent, T36 -> T67
  logic [30:0] cb_abs_t36;
  logic        tan_sat_t36, tan_sat_t67;
  logic [TAN_QW-1:0] qt_t67;
  ondf_dly #(.W(31), .D(33)) u_dly_cb (
    .clk(clk), .en(en), .din(cb_abs_r), .dout(cb_abs_t36)
  );
  // Quotient of 2^31 or more (including a zero cosine) saturates.
  assign tan_sat_t36 = 46'(sin_b_t36) >= (46'(cb_abs_t36) << 15);
  ondf_div #(.DW(TAN_DW), .QW(TAN_QW)) u_div_t (
    .clk(clk), .en(en),
    .rem0(tan_sat_t36 ? '0 : 31'(sin_b_t36[30:15])),
    .bits({sin_b_t36[14:0], 16'd0}),
    .den(cb_abs_t36), .quo(qt_t67)
  );
  ondf_dly #(.W(1), .D(31)) u_dly_tsat (
    .clk(clk), .en(en), .din(tan_sat_t36), .dout(tan_sat_t67)
  );

  // ------------------------------------------- T68..T70: product chain
  logic [30:0] tm_r, t1_r;
  logic [31:0] t2_r;
  logic [44:0] bt_r;
  logic        cb_neg_t70;
  always_ff @(posedge clk) begin
    logic [61:0] m1, m2;
    logic [60:0] m3;
    if (en) begin
      tm_r <= tan_sat_t67 ? TAN_SAT : qt_t67;
      m1   = 62'(maxcos_t67) * 62'(sin_a_t67);
      t1_r <= m1[60:30];
      m2   = 62'(t1_r) * 62'(tm_r);
      t2_r <= m2[61:30];
      m3   = 61'(qb_t69) * 61'(t2_r);
      bt_r <= m3[60:16];
    end
  end
  ondf_dly #(.W(1), .D(67)) u_dly_sign (
    .clk(clk), .en(en), .din(cb_neg_r), .dout(cb_neg_t70)
  );

  // ---------------------------------------- T71: sum, clamp, round to Q1.15
  logic [15:0] df_r, df_nxt;
  always_comb begin
    logic signed [47:0] a, r;
    a = 48'(Q_ONE) - 48'(qa_t70);
    r = cb_neg_t70 ? a - 48'(bt_r) : a + 48'(bt_r);
    if (r < 0) r = '0;
    if (r > 48'(Q_ONE)) r = 48'(Q_ONE);
    df_nxt = 16'((r + 48'sd16384) >>> 15);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      df_r <= df_nxt;
    end
  end
  assign out_diffuse_factor = df_r;

endmodule

### rtl/core/ondf_chk.sv
// ----------------------------------------------------------------------------
// ondf_chk
// Port-level checks for the diffuse factor core, bound to the top level.
// ----------------------------------------------------------------------------
module ondf_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [15:0]        out_diffuse_factor
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_diffuse_factor))
    else $error("stalled result changed");

  // factor never exceeds one
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_diffuse_factor <= 16'd32768)
    else $error("factor above one");

  // input backs up only behind a held result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  // drop all results on reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind oren_nayar_diffuse_factor_core ondf_chk u_ondf_chk (.*);

### bench/oren_nayar_diffuse_factor_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oren_nayar_diffuse_factor_core_tb
// Self-checking bench: streams direction/normal items through the core under
// several pacing and roughness settings and checks every diffuse factor
// against a bit-exact fixed-point predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
module oren_nayar_diffuse_factor_core_tb;
  import ondf_pkg::*;

  localparam int VFB = VEC_FRAC_BITS_DEF;
  localparam int LATENCY = 71;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] v[9];   // in dir xyz, out dir xyz, normal xyz
    logic               use_r;
    logic [15:0]        rough;
  } shade_item_t;

  // Scoreboard: holds the expected factors in arrival order.
  class diffuse_board;
    logic [15:0] base_rough = BASE_ROUGH_RST;
    logic [15:0] factor_q[$];
    int          errors = 0;

    static function longint round_away(longint v, int s);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : v;
      if (s == 0) return v;
      m = (m + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    static function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    static function longint cos_of(longint a[3], longint n[3]);
      longint d, lim;
      d = a[0] * n[0] + a[1] * n[1] + a[2] * n[2];
      lim = 64'sd1 <<< (2 * VFB);
      if (d > lim) d = lim;
      if (d < -lim) d = -lim;
      if (2 * VFB >= 30) return round_away(d, 2 * VFB - 30);
      return d * (64'sd1 <<< (30 - 2 * VFB));
    endfunction

    function logic [15:0] predict(shade_item_t it);
      longint wi[3], wo[3], nn[3], p1[3], p2[3];
      longint ci, co, ca, cb, caa, cba, a_q, b_q, r, dot, n1, n2;
      longint unsigned sig, s2, maxcos, sin_a, sin_b, den, num, q, tm, t, bt;
      for (int k = 0; k < 3; k++) begin
        wi[k] = it.v[k];
        wo[k] = it.v[3 + k];
        nn[k] = it.v[6 + k];
      end
      sig = it.use_r ? it.rough : base_rough;
      s2 = sig * sig;
      a_q = (64'sd1 <<< 30) - longint'((s2 << 29) / (s2 + K33_Q28));
      b_q = longint'((s2 * K45_Q30) / (s2 + K09_Q28));
      ci = cos_of(wi, nn);
      co = cos_of(wo, nn);
      maxcos = 0;
      // near-normal directions drop the azimuth term
      if (ci < COS_LIMIT && co < COS_LIMIT) begin
        for (int k = 0; k < 3; k++) begin
          p1[k] = round_away((wi[k] <<< (30 - VFB)) - round_away(nn[k] * ci, VFB), 10);
          p2[k] = round_away((wo[k] <<< (30 - VFB)) - round_away(nn[k] * co, VFB), 10);
        end
        dot = p1[0] * p2[0] + p1[1] * p2[1] + p1[2] * p2[2];
        n1 = p1[0] * p1[0] + p1[1] * p1[1] + p1[2] * p1[2];
        n2 = p2[0] * p2[0] + p2[1] * p2[1] + p2[2] * p2[2];
        if (dot > 0) begin
          den = int_sqrt(n1) * int_sqrt(n2);
          if (den != 0) begin
            if (longint'(dot) >= den) begin
              maxcos = 64'd1 << 30;
            end else begin
              num = dot;
              q = 0;
              for (int i = 0; i < 30; i++) begin
                num <<= 1;
                q <<= 1;
                if (num >= den) begin
                  num -= den;
                  q |= 1;
                end
              end
              maxcos = q;
            end
          end
        end
      end
      ca = (co >= ci) ? ci : co;
      cb = (co >= ci) ? co : ci;
      caa = (ca < 0) ? -ca : ca;
      cba = (cb < 0) ? -cb : cb;
      sin_a = int_sqrt((64'd1 << 60) - longint'(caa) * longint'(caa));
      sin_b = int_sqrt((64'd1 << 60) - longint'(cba) * longint'(cba));
      // zero beta cosine saturates the tangent
      if (cba == 0) tm = TAN_SAT;
      else begin
        tm = (sin_b << 16) / longint'(cba);
        if (tm > TAN_SAT) tm = TAN_SAT;
      end
      t = (maxcos * sin_a) >> 30;
      t = (t * tm) >> 30;
      bt = (longint'(b_q) * t) >> 16;
      r = (cb < 0) ? a_q - longint'(bt) : a_q + longint'(bt);
      if (r < 0) r = 0;
      if (r > (64'sd1 <<< 30)) r = 64'sd1 <<< 30;
      return 16'((longint'(r) + (64'd1 << 14)) >> 15);
    endfunction

    function void note(shade_item_t it);
      factor_q.push_back(predict(it));
    endfunction

    function void check(logic [15:0] got);
      logic [15:0] want;
      if (factor_q.size() == 0) begin
        $display("%0t: unexpected result, actual %0d", $time, got);
        errors++;
        return;
      end
      want = factor_q.pop_front();
      if (got !== want) begin
        $display("%0t: diffuse_factor mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;
  logic in_valid, in_stall;
  logic signed [15:0] in_dir_x, in_dir_y, in_dir_z;
  logic signed [15:0] in_out_dir_x, in_out_dir_y, in_out_dir_z;
  logic signed [15:0] in_normal_x, in_normal_y, in_normal_z;
  logic in_use_item_roughness;
  logic [15:0] in_item_roughness;
  logic out_valid, out_stall;
  logic [15:0] out_diffuse_factor;

  diffuse_board sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;

  oren_nayar_diffuse_factor_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_out_dir_x(in_out_dir_x), .in_out_dir_y(in_out_dir_y), .in_out_dir_z(in_out_dir_z),
    .in_normal_x(in_normal_x), .in_normal_y(in_normal_y), .in_normal_z(in_normal_z),
    .in_use_item_roughness(in_use_item_roughness), .in_item_roughness(in_item_roughness),
    .out_valid(out_valid), .out_stall(out_stall), .out_diffuse_factor(out_diffuse_factor)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Count cycles and bail out if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sample results at the rising edge, before the core updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_diffuse_factor);
  end

  // Receiver back-pressure, redrawn every falling edge.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // Drive one item; hold it until the core accepts it.
  task automatic push_item(input shade_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    {in_dir_x, in_dir_y, in_dir_z} = {it.v[0], it.v[1], it.v[2]};
    {in_out_dir_x, in_out_dir_y, in_out_dir_z} = {it.v[3], it.v[4], it.v[5]};
    {in_normal_x, in_normal_y, in_normal_z} = {it.v[6], it.v[7], it.v[8]};
    in_use_item_roughness = it.use_r;
    in_item_roughness = it.rough;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sb.note(it);
    @(negedge clk);
  endtask

  // Wait for every expected result, then let the pipe empty out.
  task automatic drain();
    in_valid = 0;
    while (sb.factor_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_rough(input logic [15:0] val);
    cfg_wdata = val;
    cfg_we = 1;
    @(negedge clk);
    cfg_we = 0;
    sb.base_rough = val;
  endtask

  function automatic shade_item_t mk(int ix, int iy, int iz, int ox, int oy, int oz,
                                     int nx, int ny, int nz, bit ur, int rg);
    shade_item_t it;
    it.v[0] = 16'(ix); it.v[1] = 16'(iy); it.v[2] = 16'(iz);
    it.v[3] = 16'(ox); it.v[4] = 16'(oy); it.v[5] = 16'(oz);
    it.v[6] = 16'(nx); it.v[7] = 16'(ny); it.v[8] = 16'(nz);
    it.use_r = ur;
    it.rough = 16'(rg);
    return it;
  endfunction

  // Random unit vector in Q1.14.
  task automatic unit_vec(output int x, output int y, output int z);
    real rx, ry, rz, len;
    rx = $urandom_range(2000) / 1000.0 - 1.0;
    ry = $urandom_range(2000) / 1000.0 - 1.0;
    rz = $urandom_range(2000) / 1000.0 - 1.0;
    len = $sqrt(rx * rx + ry * ry + rz * rz);
    if (len < 0.01) begin
      rx = 0; ry = 0; rz = 1; len = 1;
    end
    x = $rtoi(rx / len * 16384.0);
    y = $rtoi(ry / len * 16384.0);
    z = $rtoi(rz / len * 16384.0);
  endtask

  function automatic int raw16(bit full);
    if (full) return $signed(16'($urandom));
    return int'($urandom_range(32768)) - 16384;
  endfunction

  task automatic random_item(output shade_item_t it);
    int c[9];
    int pick, d;
    pick = $urandom_range(99);
    if (pick < 15) begin
      // noise: arbitrary components, often non-unit
      for (int k = 0; k < 9; k++) c[k] = raw16(pick < 4);
    end else begin
      unit_vec(c[6], c[7], c[8]);
      unit_vec(c[0], c[1], c[2]);
      unit_vec(c[3], c[4], c[5]);
      // flip into the normal's hemisphere most of the time
      for (int w = 0; w < 2; w++) begin
        d = c[3*w] * c[6] + c[3*w+1] * c[7] + c[3*w+2] * c[8];
        if (d < 0 && $urandom_range(99) < 85)
          for (int k = 0; k < 3; k++) c[3*w+k] = -c[3*w+k];
      end
      if (pick < 20) for (int k = 0; k < 3; k++) c[k] = c[6+k];
      else if (pick < 25) for (int k = 0; k < 3; k++) c[3+k] = c[k];
    end
    it = mk(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8],
            1'($urandom_range(1)),
            ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(32768));
  endtask

  initial begin
    shade_item_t it;
    logic [15:0] rough_set[5];
    rough_set = '{16'd0, 16'd65535, 16'd16384, 16'd1638, 16'd8000};

    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    in_valid = 0;
    out_stall = 0;
    {in_dir_x, in_dir_y, in_dir_z} = '0;
    {in_out_dir_x, in_out_dir_y, in_out_dir_z} = '0;
    {in_normal_x, in_normal_y, in_normal_z} = '0;
    in_use_item_roughness = 0;
    in_item_roughness = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed items, base roughness at its reset value, no idling.
    push_item(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 0, 0));      // zero beta cosine
    push_item(mk(0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 0, 0));      // near-normal
    push_item(mk(9000, 0, 13000, 9000, 0, 13000, 0, 0, 16384, 1, 16384));
    push_item(mk(9000, 0, 13000, -9000, 0, 13000, 0, 0, 16384, 1, 65535)); // opposite azimuth
    push_item(mk(8000, 6000, 12000, 7000, 7000, 11000, 0, 0, 16384, 1, 0));
    push_item(mk(8000, 6000, 12000, 7000, 7000, -11000, 0, 0, 16384, 1, 65535)); // below
    push_item(mk(-16384, -16384, -16384, 16384, 16384, 16384, -16384, 0, 0, 0, 65535));
    push_item(mk(32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768, 32767,
                 1, 65535));                                           // out of range
    push_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));                   // zero projection
    push_item(mk(11585, 0, 11585, 0, 11585, 11585, 0, 0, 16384, 1, 32768));
    push_item(mk(12000, 3000, 10000, 11000, 2000, 10500, 0, 0, 16384, 0, 65535));
    push_item(mk(12000, 3000, 10000, 11000, 2000, 10500, 0, 16384, 0, 1, 20000));
    push_item(mk(16384, 0, 1, 16384, 0, 2, 0, 0, 16384, 1, 30000));  // grazing
    push_item(mk(-5461, 21845, -1, 1, -21846, 5460, 16383, -16383, 1, 1, 43690));
    drain();

    // Random phases: each sets a roughness and a pacing mix.
    for (int ph = 0; ph < 5; ph++) begin
      write_rough(rough_set[ph]);
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        3: begin idle_pct = 30; stall_pct = 30; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (int n = 0; n < 320; n++) begin
        random_item(it);
        push_item(it);
        // hold the sender once until the pipe has fully answered
        if (ph == 2 && n == 160) begin
          in_valid = 0;
          while (sb.factor_q.size() != 0) @(posedge clk);
          @(negedge clk);
        end
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
